// ----- sv/bdd_computed_table_cache_core_defines.svh -----
// Assertion macros shared by the computed table cache RTL.
`ifndef BDD_COMPUTED_TABLE_CACHE_CORE_DEFINES_SVH
`define BDD_COMPUTED_TABLE_CACHE_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Cause in one cycle implies effect in the next cycle.
`define CTC_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ----- sv/ctc_pkg.sv -----
// Types, constants and the hash step shared by the computed table cache.
`timescale 1ns / 1ps
package ctc_pkg;

    localparam int ID_W   = 32;
    localparam int KEY_W  = 32;
    localparam int LOG2_W = 5;
    localparam int CNT_W  = 23;

    localparam logic [63:0]      HASH_CONST = 64'h0000_0000_9e37_79b9;
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] THR_RESET  = 23'd1;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    // One queued word: the request fields plus its hash.
    typedef struct packed {
        cmd_t              cmd;
        logic [ID_W-1:0]   f_id;
        logic [ID_W-1:0]   g_id;
        logic [ID_W-1:0]   h_id;
        logic [KEY_W-1:0]  f_key;
        logic [KEY_W-1:0]  g_key;
        logic [ID_W-1:0]   result;
        logic [63:0]       mix;
    } item_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_LK_CMP,
        ST_SW_RD,
        ST_SW_H1,
        ST_SW_H2,
        ST_SW_WHI,
        ST_SW_WLO,
        ST_INS_WR
    } state_t;

    // One round of the hash combine, modulo 2^64.
    function automatic logic [63:0] mix_step(input logic [63:0] x, input logic [63:0] y);
        return x ^ (y + HASH_CONST + (x << 6) + (x >> 2));
    endfunction

endpackage

// ----- sv/ctc_if.sv -----
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps
interface ctc_req_if import ctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ID_W-1:0]   f_id;
    logic [ID_W-1:0]   g_id;
    logic [ID_W-1:0]   h_id;
    logic [KEY_W-1:0]  f_key;
    logic [KEY_W-1:0]  g_key;
    logic [ID_W-1:0]   insert_result;
    modport source (output valid, cmd, f_id, g_id, h_id, f_key, g_key, insert_result,
                    input ready);
    modport sink (input valid, cmd, f_id, g_id, h_id, f_key, g_key, insert_result,
                  output ready);
endinterface

interface ctc_rsp_if import ctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [ID_W-1:0]   found_result;
    logic [LOG2_W-1:0] size_log2;
    modport source (output valid, hit, found_result, size_log2, input ready);
    modport sink (input valid, hit, found_result, size_log2, output ready);
endinterface

interface ctc_cfg_if import ctc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] initial_threshold;
    modport source (output valid, initial_threshold, input ready);
    modport sink (input valid, initial_threshold, output ready);
endinterface

// ----- sv/ctc_front.sv -----
// Front end: accepts request words, masks ids and computes the slot hash in two stages.
`timescale 1ns / 1ps
module ctc_front import ctc_pkg::*; #(
    parameter int NODE_ID_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ctc_req_if.sink    req,
    output item_t      q_data,
    output logic       q_valid,
    input  logic       q_ready
);

    localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << NODE_ID_BITS) - 64'd1);

    logic  a_valid_reg, b_valid_reg;
    item_t a_item_reg, b_item_reg;
    item_t a_item_next, b_item_next;
    logic  b_free, a_move, a_free, accept;

    // Stall chain from the queue back to the request port.
    assign b_free    = !b_valid_reg || q_ready;
    assign a_move    = a_valid_reg && b_free;
    assign a_free    = !a_valid_reg || a_move;
    assign req.ready = a_free;
    assign accept    = req.valid && a_free;
    assign q_valid   = b_valid_reg;
    assign q_data    = b_item_reg;

    // First hash round on the incoming word.
    always_comb
    begin
        a_item_next.cmd    = cmd_t'(req.cmd);
        a_item_next.f_id   = req.f_id & ID_MASK;
        a_item_next.g_id   = req.g_id & ID_MASK;
        a_item_next.h_id   = req.h_id & ID_MASK;
        a_item_next.f_key  = req.f_key;
        a_item_next.g_key  = req.g_key;
        a_item_next.result = req.insert_result & ID_MASK;
        a_item_next.mix    = mix_step(64'(req.f_key), 64'(req.g_key) << 1);
    end

    // Second hash round folds in the h id.
    always_comb
    begin
        b_item_next     = a_item_reg;
        b_item_next.mix = mix_step(a_item_reg.mix, 64'(a_item_reg.h_id) << 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= req.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= a_item_next;
        end
        if (a_move)
        begin
            b_item_reg <= b_item_next;
        end
    end

endmodule

// ----- sv/ctc_fifo.sv -----
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module ctc_fifo import ctc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t wr_data,
    input  logic  wr_valid,
    output logic  wr_ready,
    output item_t rd_data,
    input  logic  rd_ready,
    output logic  rd_valid
);

    item_t      slots_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slots_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/ctc_back.sv -----
// Back end: table memory, lookup and insert sequencer, doubling sweep and result register.
`timescale 1ns / 1ps
`include "bdd_computed_table_cache_core_defines.svh"
module ctc_back import ctc_pkg::*; #(
    parameter int MAX_LOG2_SIZE = 12,
    parameter int NODE_ID_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     q_data,
    input  logic      q_valid,
    output logic      q_ready,
    ctc_rsp_if.source rsp,
    ctc_cfg_if.sink   cfg
);

    localparam int AW     = MAX_LOG2_SIZE;
    localparam int DEPTH  = 1 << AW;
    localparam int N      = NODE_ID_BITS;
    localparam int OFF_GK = 0;
    localparam int OFF_FK = KEY_W;
    localparam int OFF_R  = 2 * KEY_W;
    localparam int OFF_H  = OFF_R + N;
    localparam int OFF_G  = OFF_H + N;
    localparam int OFF_F  = OFF_G + N;
    localparam int OFF_V  = OFF_F + N;
    localparam int EW     = OFF_V + 1;

    // Slot under a table of 2^lg entries.
    function automatic logic [AW-1:0] slot_of(input logic [63:0] x,
                                              input logic [LOG2_W-1:0] lg);
        logic [AW:0] m;
        m = ((AW+1)'(1) << lg) - (AW+1)'(1);
        return x[AW-1:0] & m[AW-1:0];
    endfunction

    function automatic logic [EW-1:0] make_entry(input item_t it);
        return {1'b1, it.f_id[N-1:0], it.g_id[N-1:0], it.h_id[N-1:0],
                it.result[N-1:0], it.f_key, it.g_key};
    endfunction

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    item_t             cur_reg, cur_next;
    logic [LOG2_W-1:0] log2_reg, log2_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     old_reg, old_next;
    logic [63:0]       sw_x_reg, sw_x_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              hit_reg, hit_next;
    logic [ID_W-1:0]   found_reg, found_next;
    logic [LOG2_W-1:0] size_reg, size_next;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr, sw_slot;
    logic [EW-1:0]     wr_data;
    logic              out_free, load, sw_vld, moved, lk_hit, sw_last;
    logic [CNT_W-1:0]  cnt_inc;

    assign out_free         = !rsp_valid_reg || rsp.ready;
    assign q_ready          = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.found_result = found_reg;
    assign rsp.size_log2    = size_reg;

    assign cnt_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);
    assign sw_vld  = rd_data_reg[OFF_V];
    assign sw_slot = slot_of(sw_x_reg, log2_reg);
    assign moved   = sw_vld && (sw_slot != k_reg);
    assign sw_last = (k_reg == old_reg - AW'(1));
    assign lk_hit  = rd_data_reg[OFF_V]
                     && (rd_data_reg[OFF_F +: N] == cur_reg.f_id[N-1:0])
                     && (rd_data_reg[OFF_G +: N] == cur_reg.g_id[N-1:0])
                     && (rd_data_reg[OFF_H +: N] == cur_reg.h_id[N-1:0]);

    // Sequencer: next state, memory controls and result load.
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        log2_next  = log2_reg;
        count_next = count_reg;
        thr_next   = thr_reg;
        occ_next   = occ_reg;
        k_next     = k_reg;
        old_next   = old_reg;
        sw_x_next  = sw_x_reg;
        hit_next   = hit_reg;
        found_next = found_reg;
        size_next  = size_reg;
        load       = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = k_reg;
        wr_en      = 1'b0;
        wr_addr    = k_reg;
        wr_data    = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                // Only slot 0 is in range after reset; higher slots are written
                // by the doubling sweep before they come into range.
                wr_en      = 1'b1;
                wr_addr    = '0;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next = q_data;
                    if (q_data.cmd == CMD_LOOKUP)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = slot_of(q_data.mix, log2_reg);
                        state_next = ST_LK_CMP;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        if ((cnt_inc >= thr_reg) && (log2_reg < LOG2_W'(MAX_LOG2_SIZE)))
                        begin
                            old_next   = AW'(1) << log2_reg;
                            log2_next  = log2_reg + LOG2_W'(1);
                            thr_next   = CNT_W'(old_next) + CNT_W'(1);
                            k_next     = '0;
                            occ_next   = '0;
                            state_next = ST_SW_RD;
                        end
                        else
                        begin
                            state_next = ST_INS_WR;
                        end
                    end
                end
            end
            ST_LK_CMP:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    hit_next   = lk_hit;
                    found_next = lk_hit ? ID_W'(rd_data_reg[OFF_R +: N]) : '0;
                    size_next  = log2_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_SW_H1;
            end
            ST_SW_H1:
            begin
                sw_x_next  = mix_step(64'(rd_data_reg[OFF_FK +: KEY_W]),
                                      64'(rd_data_reg[OFF_GK +: KEY_W]) << 1);
                state_next = ST_SW_H2;
            end
            ST_SW_H2:
            begin
                sw_x_next  = mix_step(sw_x_reg, 64'(rd_data_reg[OFF_H +: N]) << 2);
                state_next = ST_SW_WHI;
            end
            ST_SW_WHI:
            begin
                // Upper-half slot always gets written so stale contents die here.
                wr_en    = 1'b1;
                wr_addr  = k_reg | old_reg;
                wr_data  = {moved, rd_data_reg[EW-2:0]};
                occ_next = occ_reg + CNT_W'(sw_vld);
                if (moved)
                begin
                    state_next = ST_SW_WLO;
                end
                else if (sw_last)
                begin
                    count_next = occ_next;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_SW_WLO:
            begin
                // The entry left its old slot.
                wr_en   = 1'b1;
                wr_addr = k_reg;
                if (sw_last)
                begin
                    count_next = occ_reg;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(cur_reg.mix, log2_reg);
                wr_data = make_entry(cur_reg);
                if (out_free)
                begin
                    load       = 1'b1;
                    hit_next   = 1'b0;
                    found_next = '0;
                    size_next  = log2_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg.valid)
        begin
            thr_next = cfg.initial_threshold;
        end
        rsp_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            log2_reg      <= '0;
            count_reg     <= '0;
            thr_reg       <= THR_RESET;
            occ_reg       <= '0;
            k_reg         <= '0;
            old_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            log2_reg      <= log2_next;
            count_reg     <= count_next;
            thr_reg       <= thr_next;
            occ_reg       <= occ_next;
            k_reg         <= k_next;
            old_reg       <= old_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        sw_x_reg  <= sw_x_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        size_reg  <= size_next;
    end

    // Table memory, one access per cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `CTC_ASSERT(a_single_port, !(rd_en && wr_en), "table read and write in one cycle")
    `CTC_ASSERT(a_size_cap, (log2_reg <= LOG2_W'(MAX_LOG2_SIZE)), "table beyond maximum size")
    `CTC_ASSERT(a_grow_start, (!$stable(log2_reg) |-> (state_reg == ST_SW_RD)), "size changed outside a sweep")
    `CTC_ASSERT(a_sweep_range, ((state_reg == ST_SW_WHI) |-> (k_reg < old_reg)), "sweep index past old half")
    `CTC_ASSERT_NEXT(a_sweep_step, (state_reg == ST_SW_WLO), (state_reg == ST_SW_RD || state_reg == ST_INS_WR), "sweep lost its place")

endmodule

// ----- sv/bdd_computed_table_cache_core.sv -----
// Top level of the computed table cache: front end, queue and back end.
//
//   Channel  Dir  Handshake       Word
//   req      in   valid/ready     cmd, f_id, g_id, h_id, f_key, g_key, insert_result
//   rsp      out  valid/ready     hit, found_result, size_log2
//   cfg      in   valid/ready     initial_threshold (ready always high)
//
// In the back end a lookup or an insert is one table read or write plus the result load;
// the front end adds 2 hash stages.
// An insert that doubles the table first sweeps the old half, rehashing each slot and
// moving its entry to the upper half when its slot changes, with requests stalled meanwhile.
// After reset the back end clears slot 0 before taking words.
// A full result register stalls the back end; the queue and front end keep accepting until they fill.
`timescale 1ns / 1ps
module bdd_computed_table_cache_core import ctc_pkg::*; #(
    parameter int MAX_LOG2_SIZE = 12,
    parameter int NODE_ID_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ctc_req_if.sink   req,
    ctc_rsp_if.source rsp,
    ctc_cfg_if.sink   cfg
);

    item_t f_data, b_data;
    logic  f_valid, f_ready, b_valid, b_ready;

    // Request hashing.
    ctc_front #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_data  (f_data),
        .q_valid (f_valid),
        .q_ready (f_ready)
    );

    // Decoupling queue.
    ctc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_data),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (b_data),
        .rd_ready (b_ready),
        .rd_valid (b_valid)
    );

    // Table access and growth.
    ctc_back #(
        .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
        .NODE_ID_BITS  (NODE_ID_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (b_data),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .rsp     (rsp),
        .cfg     (cfg)
    );

endmodule

// ----- tb/sv/ctc_scoreboard.sv -----
// Checker for the computed table cache: tracks table state, predicts responses, compares.
`timescale 1ns / 1ps
module ctc_scoreboard import ctc_pkg::*; #(
    parameter int MAX_LOG2 = 12
) (
    input  logic clk,
    input  logic rst_n,
    ctc_req_if   req,
    ctc_rsp_if   rsp,
    ctc_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output int   hits_seen
);

    localparam int DEPTH = 1 << MAX_LOG2;

    typedef struct {
        logic              hit;
        logic [ID_W-1:0]   found;
        logic [LOG2_W-1:0] size;
    } rsp_word_t;

    // Shadow copy of the cache contents and sizing state.
    logic              slot_valid [DEPTH];
    logic [ID_W-1:0]   slot_f     [DEPTH];
    logic [ID_W-1:0]   slot_g     [DEPTH];
    logic [ID_W-1:0]   slot_h     [DEPTH];
    logic [ID_W-1:0]   slot_res   [DEPTH];
    logic [KEY_W-1:0]  slot_fkey  [DEPTH];
    logic [KEY_W-1:0]  slot_gkey  [DEPTH];
    logic [LOG2_W-1:0] cur_log2;
    logic [CNT_W-1:0]  ins_count;
    logic [CNT_W-1:0]  grow_at;

    rsp_word_t expected_rsp [$];

    // Hash combine of the two keys and the h id, modulo 2^64.
    function automatic logic [63:0] triple_hash(input logic [31:0] fk, input logic [31:0] gk,
                                                input logic [31:0] hid);
        logic [63:0] x;
        x = {32'd0, fk};
        x = x ^ (({32'd0, gk} << 1) + HASH_CONST + (x << 6) + (x >> 2));
        x = x ^ (({32'd0, hid} << 2) + HASH_CONST + (x << 6) + (x >> 2));
        return x;
    endfunction

    function automatic int slot_index(input logic [63:0] x, input logic [LOG2_W-1:0] lg);
        return int'(x[MAX_LOG2-1:0] & ((MAX_LOG2'(1) << lg) - 1'b1));
    endfunction

    // Double the table: rehash the old half and move entries whose slot changes.
    task automatic double_table();
        int old_size;
        int occupied;
        int dst;
        if (cur_log2 >= LOG2_W'(MAX_LOG2))
            return;
        old_size = 1 << cur_log2;
        grow_at = CNT_W'(old_size + 1);
        cur_log2 = cur_log2 + 1'b1;
        occupied = 0;
        for (int k = 0; k < old_size; k++)
        begin
            if (!slot_valid[k])
                continue;
            occupied++;
            dst = slot_index(triple_hash(slot_fkey[k], slot_gkey[k], slot_h[k]), cur_log2);
            if (dst != k)
            begin
                slot_valid[dst] = 1'b1;
                slot_f[dst] = slot_f[k];
                slot_g[dst] = slot_g[k];
                slot_h[dst] = slot_h[k];
                slot_res[dst] = slot_res[k];
                slot_fkey[dst] = slot_fkey[k];
                slot_gkey[dst] = slot_gkey[k];
                slot_valid[k] = 1'b0;
            end
        end
        ins_count = CNT_W'(occupied);
    endtask

    // Apply one accepted request word and queue the response it should produce.
    task automatic predict_lookup_or_insert();
        rsp_word_t w;
        int s;
        w.hit = 1'b0;
        w.found = '0;
        if (cmd_t'(req.cmd) == CMD_LOOKUP)
        begin
            s = slot_index(triple_hash(req.f_key, req.g_key, req.h_id), cur_log2);
            if (slot_valid[s] && slot_f[s] == req.f_id && slot_g[s] == req.g_id
                && slot_h[s] == req.h_id)
            begin
                w.hit = 1'b1;
                w.found = slot_res[s];
            end
        end
        else
        begin
            if (ins_count != CNT_MAX)
                ins_count = ins_count + 1'b1;
            if (ins_count >= grow_at)
                double_table();
            s = slot_index(triple_hash(req.f_key, req.g_key, req.h_id), cur_log2);
            slot_valid[s] = 1'b1;
            slot_f[s] = req.f_id;
            slot_g[s] = req.g_id;
            slot_h[s] = req.h_id;
            slot_res[s] = req.insert_result;
            slot_fkey[s] = req.f_key;
            slot_gkey[s] = req.g_key;
        end
        w.size = cur_log2;
        expected_rsp.push_back(w);
    endtask

    // Compare one accepted response word against the oldest expectation.
    task automatic compare_response();
        rsp_word_t w;
        if (expected_rsp.size() == 0)
        begin
            $error("response word with nothing expected");
            errors++;
            return;
        end
        w = expected_rsp.pop_front();
        if (rsp.hit !== w.hit)
        begin
            $error("hit: expected %0b actual %0b", w.hit, rsp.hit);
            errors++;
        end
        if (rsp.found_result !== w.found)
        begin
            $error("found_result: expected %0h actual %0h", w.found, rsp.found_result);
            errors++;
        end
        if (rsp.size_log2 !== w.size)
        begin
            $error("size_log2: expected %0d actual %0d", w.size, rsp.size_log2);
            errors++;
        end
        if (w.hit)
            hits_seen++;
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                slot_valid[k] = 1'b0;
            cur_log2 = '0;
            ins_count = '0;
            grow_at = THR_RESET;
            expected_rsp.delete();
            errors = 0;
            hits_seen = 0;
        end
        else
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
                grow_at = cfg.initial_threshold;
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                compare_response();
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predict_lookup_or_insert();
        end
        pending = expected_rsp.size();
    end

endmodule

// ----- tb/sv/tb_bdd_computed_table_cache_core.sv -----
// Testbench top for the computed table cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_bdd_computed_table_cache_core;
    import ctc_pkg::*;

    localparam int POOL_N = 48;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   hits_seen;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   words_sent;

    // Pool of recurring triples so that lookups find earlier inserts.
    logic [31:0] pool_f    [POOL_N];
    logic [31:0] pool_g    [POOL_N];
    logic [31:0] pool_h    [POOL_N];
    logic [31:0] pool_fkey [POOL_N];
    logic [31:0] pool_gkey [POOL_N];

    ctc_req_if req ();
    ctc_rsp_if rsp ();
    ctc_cfg_if cfg ();

    bdd_computed_table_cache_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    ctc_scoreboard checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .errors    (errors),
        .pending   (pending),
        .hits_seen (hits_seen)
    );

    always #10 clk = ~clk;

    // Response side stalls at the rate of the current phase.
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= snk_stall_pct);

    function automatic logic [31:0] nonzero_id();
        logic [31:0] v;
        v = $urandom();
        if (v == 0)
            v = 32'd1;
        return v;
    endfunction

    // Present one request word, with an optional gap first, and wait for acceptance.
    task automatic send_word(input cmd_t c, input logic [31:0] f, input logic [31:0] g,
                             input logic [31:0] h, input logic [31:0] fk,
                             input logic [31:0] gk, input logic [31:0] res);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.f_id <= f;
        req.g_id <= g;
        req.h_id <= h;
        req.f_key <= fk;
        req.g_key <= gk;
        req.insert_result <= res;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        words_sent++;
    endtask

    // Write the threshold register once the block has drained.
    task automatic write_threshold(input logic [CNT_W-1:0] v);
        req.valid <= 1'b0;
        // This edge lets the checker record the last accepted word.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.initial_threshold <= v;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic refill_pool();
        for (int k = 0; k < POOL_N; k++)
        begin
            pool_f[k] = nonzero_id();
            pool_g[k] = nonzero_id();
            pool_h[k] = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
            pool_fkey[k] = $urandom();
            pool_gkey[k] = $urandom();
        end
    endtask

    // Mostly pool triples, some fresh random triples.
    task automatic random_phase(input int n);
        int p;
        cmd_t c;
        logic [31:0] res;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(199) == 0)
                refill_pool();
            c = ($urandom_range(1) == 0) ? CMD_LOOKUP : CMD_INSERT;
            res = ($urandom_range(15) == 0) ? 32'd0 : $urandom();
            if ($urandom_range(9) < 7)
            begin
                p = $urandom_range(POOL_N - 1);
                send_word(c, pool_f[p], pool_g[p], pool_h[p], pool_fkey[p], pool_gkey[p], res);
            end
            else
                send_word(c, nonzero_id(), nonzero_id(), $urandom(), $urandom(), $urandom(),
                          res);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        words_sent = 0;
        req.valid = 1'b0;
        req.cmd = CMD_LOOKUP;
        req.f_id = '0;
        req.g_id = '0;
        req.h_id = '0;
        req.f_key = '0;
        req.g_key = '0;
        req.insert_result = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.initial_threshold = '0;
        refill_pool();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero result, hits, misses on a differing f or h id.
        send_word(CMD_LOOKUP, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_INSERT, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_LOOKUP, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'hffff_ffff);
        send_word(CMD_INSERT, '1, '1, '1, '1, '1, '1);
        send_word(CMD_LOOKUP, '1, '1, '1, '1, '1, 32'd0);
        send_word(CMD_LOOKUP, '1, '1, 32'd0, '1, '1, 32'd0);
        send_word(CMD_LOOKUP, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa,
                  32'h8000_0001, 32'h7fff_fffe, 32'h1234_5678);
        send_word(CMD_LOOKUP, 32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa,
                  32'h8000_0001, 32'h7fff_fffe, 32'd0);
        send_word(CMD_LOOKUP, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
                  32'h8000_0001, 32'h7fff_fffe, 32'd0);
        for (int k = 0; k < 6; k++)
        begin
            send_word(CMD_INSERT, pool_f[k], pool_g[k], pool_h[k], pool_fkey[k], pool_gkey[k],
                      $urandom());
            send_word(CMD_LOOKUP, pool_f[k], pool_g[k], pool_h[k], pool_fkey[k], pool_gkey[k],
                      32'd0);
        end

        // Random phases, each under its own threshold and idling pattern.
        write_threshold(23'd4194305);
        random_phase(475);
        src_idle_pct = 72;
        write_threshold(23'd40);
        random_phase(475);
        src_idle_pct = 0;
        snk_stall_pct = 72;
        write_threshold(23'd1);
        random_phase(475);
        src_idle_pct = 28;
        snk_stall_pct = 28;
        write_threshold(CNT_W'($urandom_range(4194305, 1)));
        random_phase(475);

        // Drain and give the verdict.
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d request words over four threshold settings and idling patterns;",
                 words_sent);
        $display("%0d lookups hit in the cache.", hits_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
